// ===== sv/chlx_pkg.sv =====
// Shared types, codes and segment tables for the charlieplex digit scanner.
`default_nettype none

package chlx_pkg;

    // Item kind codes
    typedef logic [2:0] kind_t;
    localparam kind_t KIND_SET     = 3'd0;
    localparam kind_t KIND_CLEAR   = 3'd1;
    localparam kind_t KIND_CHARGE  = 3'd2;
    localparam kind_t KIND_PERCENT = 3'd3;
    localparam kind_t KIND_TICK    = 3'd4;

    // Segment image, pin vectors and scan phase
    typedef logic [19:0] seg_t;
    typedef logic [4:0]  pins_t;
    typedef logic [2:0]  phase_t;

    typedef struct packed {
        pins_t enable;
        pins_t level;
    } drive_t;

    localparam phase_t PHASE_1 = 3'd1;
    localparam phase_t PHASE_2 = 3'd2;
    localparam phase_t PHASE_3 = 3'd3;
    localparam phase_t PHASE_4 = 3'd4;
    localparam phase_t PHASE_5 = 3'd5;

    localparam logic [7:0] NUM_CLAMP   = 8'd199;
    localparam logic [7:0] NUM_HUNDRED = 8'd100;
    localparam logic [7:0] LAST_RESET  = 8'hFF;

    // Bit positions in the segment image
    localparam int unsigned SEG_A3 = 0;
    localparam int unsigned SEG_B3 = 1;
    localparam int unsigned SEG_C3 = 2;
    localparam int unsigned SEG_D3 = 3;
    localparam int unsigned SEG_E3 = 4;
    localparam int unsigned SEG_F3 = 5;
    localparam int unsigned SEG_G3 = 6;
    localparam int unsigned SEG_A2 = 8;
    localparam int unsigned SEG_B2 = 9;
    localparam int unsigned SEG_C2 = 10;
    localparam int unsigned SEG_D2 = 11;
    localparam int unsigned SEG_E2 = 12;
    localparam int unsigned SEG_F2 = 13;
    localparam int unsigned SEG_G2 = 14;
    localparam int unsigned SEG_B1 = 16;
    localparam int unsigned SEG_C1 = 17;
    localparam int unsigned SEG_K1 = 18;
    localparam int unsigned SEG_K2 = 19;

    // Seven-segment pattern, A on bit 0 through G on bit 6
    function automatic logic [6:0] seg7(input logic [3:0] digit);
        logic [6:0] pat;
        begin
            unique case (digit)
                4'd0:    pat = 7'h3F;
                4'd1:    pat = 7'h06;
                4'd2:    pat = 7'h5B;
                4'd3:    pat = 7'h4F;
                4'd4:    pat = 7'h66;
                4'd5:    pat = 7'h6D;
                4'd6:    pat = 7'h7D;
                4'd7:    pat = 7'h07;
                4'd8:    pat = 7'h7F;
                4'd9:    pat = 7'h6F;
                default: pat = 7'h00;
            endcase
            return pat;
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/chlx_pin_map.sv =====
// Maps the segment image and the scan phase onto the five tri-state pins.
`default_nettype none

module chlx_pin_map (
    input  wire chlx_pkg::seg_t   segs,
    input  wire chlx_pkg::phase_t phase,
    output chlx_pkg::drive_t      drive
);
    import chlx_pkg::*;

    // Common pin high, lit segment pins pulled low
    always_comb
    begin
        drive = '0;
        unique case (phase)
            PHASE_1:
            begin
                drive.level  = 5'b00001;
                drive.enable = {1'b0, segs[SEG_E3], segs[SEG_C3], segs[SEG_A3], 1'b1};
            end
            PHASE_2:
            begin
                drive.level  = 5'b00010;
                drive.enable = {segs[SEG_K2], segs[SEG_C1], segs[SEG_A2], 1'b1, segs[SEG_B3]};
            end
            PHASE_3:
            begin
                drive.level  = 5'b00100;
                drive.enable = {segs[SEG_K1], segs[SEG_B1], 1'b1, segs[SEG_B2], segs[SEG_D3]};
            end
            PHASE_4:
            begin
                drive.level  = 5'b01000;
                drive.enable = {1'b0, 1'b1, segs[SEG_C2], segs[SEG_D2], segs[SEG_F3]};
            end
            PHASE_5:
            begin
                drive.level  = 5'b10000;
                drive.enable = {1'b1, segs[SEG_G2], segs[SEG_F2], segs[SEG_E2], segs[SEG_G3]};
            end
            default:
            begin
                drive = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/charlieplex_led_digit_scanner_top.sv =====
// Top level of the charlieplexed 2.5-digit LED scanner.
//
//   channel | direction | handshake          | fields
//   --------+-----------+--------------------+-----------------------------------
//   in      | input     | in_valid, in_stall | kind, number, enable
//   out     | output    | out_valid, out_stall | drive_enable, drive_level, scan_phase
//
// One item per cycle unless a tick waits on a stalled result: an item is held
// in the input register and updates the display state at the edge it leaves; a
// scan tick's drive is captured in the output register at that same edge, so a
// tick's result passes the input and output registers. Reset clears the segment
// image, sets the cached number to 255 and the phase to 1. A stalled result holds
// the output register; only a tick waiting behind it stalls the input, others flow.
`default_nettype none

module charlieplex_led_digit_scanner_top (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_stall,
    input  wire chlx_pkg::kind_t   kind,
    input  wire  [7:0]             number,
    input  wire                    enable,
    output logic                   out_valid,
    input  wire                    out_stall,
    output chlx_pkg::pins_t        drive_enable,
    output chlx_pkg::pins_t        drive_level,
    output chlx_pkg::phase_t       scan_phase
);
    import chlx_pkg::*;

    // Input register
    logic        s1_valid_reg;
    kind_t       s1_kind_reg;
    logic [7:0]  s1_number_reg;
    logic        s1_enable_reg;

    // Display state
    seg_t        segs_reg,  segs_next;
    logic [7:0]  last_reg,  last_next;
    phase_t      phase_reg, phase_next;

    // Output register
    logic        out_valid_reg;
    pins_t       drive_enable_reg;
    pins_t       drive_level_reg;
    phase_t      scan_phase_reg;

    logic        in_xfer;
    logic        out_free;
    logic        s1_is_tick;
    logic        s1_fire;

    // Number decode
    logic [7:0]  num_clamped;
    logic        num_hundred;
    logic [6:0]  num_rem;
    logic [13:0] tens_prod;
    logic [3:0]  num_tens;
    logic [6:0]  tens_x10;
    logic [3:0]  num_units;
    seg_t        num_segs;

    drive_t      drive;

    // Handshake
    assign in_xfer    = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_is_tick = (s1_kind_reg == KIND_TICK);
    assign s1_fire    = s1_valid_reg && (!s1_is_tick || out_free);
    assign in_stall   = s1_valid_reg && !s1_fire;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_kind_reg   <= kind;
            s1_number_reg <= number;
            s1_enable_reg <= enable;
        end
    end

    // Clamp, split into hundreds, tens and units (tens by x103 >> 10, exact to 99)
    always_comb
    begin
        num_clamped = (s1_number_reg > NUM_CLAMP) ? NUM_CLAMP : s1_number_reg;
        num_hundred = (num_clamped >= NUM_HUNDRED);
        num_rem     = num_hundred ? 7'(num_clamped - NUM_HUNDRED) : num_clamped[6:0];
        tens_prod   = 14'(num_rem) * 14'd103;
        num_tens    = tens_prod[13:10];
        tens_x10    = 7'({num_tens, 3'b000}) + 7'({num_tens, 1'b0});
        num_units   = 4'(num_rem - tens_x10);
        num_segs    = '0;
        num_segs[SEG_K1] = segs_reg[SEG_K1];
        num_segs[SEG_K2] = segs_reg[SEG_K2];
        num_segs[SEG_B1] = num_hundred;
        num_segs[SEG_C1] = num_hundred;
        num_segs[SEG_G2:SEG_A2] = seg7(num_tens);
        num_segs[SEG_G3:SEG_A3] = seg7(num_units);
    end

    // State update per item kind
    always_comb
    begin
        segs_next  = segs_reg;
        last_next  = last_reg;
        phase_next = phase_reg;
        if (s1_fire)
        begin
            unique case (s1_kind_reg)
                KIND_SET:
                begin
                    if (s1_number_reg != last_reg)
                    begin
                        last_next = s1_number_reg;
                        segs_next = num_segs;
                    end
                end
                KIND_CLEAR:
                begin
                    segs_next = '0;
                end
                KIND_CHARGE:
                begin
                    segs_next[SEG_K1] = s1_enable_reg;
                end
                KIND_PERCENT:
                begin
                    segs_next[SEG_K2] = s1_enable_reg;
                end
                KIND_TICK:
                begin
                    phase_next = (phase_reg == PHASE_5) ? PHASE_1 : phase_t'(phase_reg + 3'd1);
                end
                default:
                begin
                    segs_next = segs_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segs_reg  <= '0;
            last_reg  <= LAST_RESET;
            phase_reg <= PHASE_1;
        end
        else
        begin
            segs_reg  <= segs_next;
            last_reg  <= last_next;
            phase_reg <= phase_next;
        end
    end

    // Pin drive for the current phase
    chlx_pin_map u_pin_map (
        .segs  (segs_reg),
        .phase (phase_reg),
        .drive (drive)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_is_tick)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_is_tick)
        begin
            drive_enable_reg <= drive.enable;
            drive_level_reg  <= drive.level;
            scan_phase_reg   <= phase_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign drive_enable = drive_enable_reg;
    assign drive_level  = drive_level_reg;
    assign scan_phase   = scan_phase_reg;

endmodule

`default_nettype wire

// ===== sv/chlx_checker.sv =====
// Port-level checks for the charlieplex digit scanner, bound to the top level.
`default_nettype none

module chlx_checker (
    input wire                   clk,
    input wire                   rst_n,
    input wire                   out_valid,
    input wire                   out_stall,
    input wire chlx_pkg::pins_t  drive_enable,
    input wire chlx_pkg::pins_t  drive_level,
    input wire chlx_pkg::phase_t scan_phase
);
    import chlx_pkg::*;

    // Only the common pin of the phase is driven high
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (scan_phase == PHASE_1 && drive_level == 5'b00001)
                   || (scan_phase == PHASE_2 && drive_level == 5'b00010)
                   || (scan_phase == PHASE_3 && drive_level == 5'b00100)
                   || (scan_phase == PHASE_4 && drive_level == 5'b01000)
                   || (scan_phase == PHASE_5 && drive_level == 5'b10000))
        else $error("drive level does not match scan phase");

    // A high pin is always a driven pin
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((drive_level & ~drive_enable) == 5'b00000))
        else $error("high level on a Hi-Z pin");

    // Pin 4 stays Hi-Z in phases 1 and 4, and the common pin of phase 4 is driven
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !((scan_phase == PHASE_1 && drive_enable[4])
                     || (scan_phase == PHASE_4 && drive_enable[4]))
                   && !(scan_phase == PHASE_4 && !drive_enable[3]))
        else $error("unmapped pin driven");

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(drive_enable)
                                 && $stable(drive_level) && $stable(scan_phase))
        else $error("stalled result changed");

endmodule

bind charlieplex_led_digit_scanner_top chlx_checker u_chlx_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .drive_enable (drive_enable),
    .drive_level  (drive_level),
    .scan_phase   (scan_phase)
);

`default_nettype wire

// ===== test/tb_charlieplex_led_digit_scanner_top.sv =====
`timescale 1ns / 100ps
// Testbench for the charlieplex digit scanner: directed table plus random items vs. a display model.
module tb_charlieplex_led_digit_scanner_top;
    import chlx_pkg::*;

    // Kinds the block must ignore
    localparam kind_t KIND_RSVD_FIRST = 3'd5;
    localparam kind_t KIND_RSVD_LAST  = 3'd7;

    localparam int RANDOM_ITEMS   = 2000;
    localparam int PAUSE_AT       = 1000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIRECTED_ROWS  = 25;

    // Seven-segment patterns, A on bit 0 through G on bit 6
    localparam logic [6:0] DIGIT_PAT [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    typedef struct packed {
        pins_t  en;
        pins_t  lv;
        phase_t ph;
    } drive_exp_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] number;
        logic       enable;
        logic       typed;
        drive_exp_t drive;
    } row_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    kind_t      kind      = KIND_TICK;
    logic [7:0] number    = 8'd0;
    logic       enable    = 1'b0;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    pins_t      drive_enable;
    pins_t      drive_level;
    phase_t     scan_phase;

    // Display model state
    seg_t       disp_bits;
    logic [7:0] cached_num;
    phase_t     next_phase;

    drive_exp_t drive_q [$];
    int         mismatches  = 0;
    int         burst_left  = 0;
    int         idle_cycles = 0;
    int         stall_left  = 0;
    int         stall_mode  = 0;
    int         stall_tick  = 0;
    row_t       directed_rows [DIRECTED_ROWS];

    charlieplex_led_digit_scanner_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .number       (number),
        .enable       (enable),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .drive_enable (drive_enable),
        .drive_level  (drive_level),
        .scan_phase   (scan_phase)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Pins pulled low for the lit segments of one phase
    function automatic pins_t lit_pins(input phase_t ph, input seg_t s);
        pins_t p;
        p = '0;
        case (ph)
            PHASE_1:
            begin
                p[1] = s[SEG_A3]; p[2] = s[SEG_C3]; p[3] = s[SEG_E3];
            end
            PHASE_2:
            begin
                p[0] = s[SEG_B3]; p[2] = s[SEG_A2]; p[3] = s[SEG_C1]; p[4] = s[SEG_K2];
            end
            PHASE_3:
            begin
                p[0] = s[SEG_D3]; p[1] = s[SEG_B2]; p[3] = s[SEG_B1]; p[4] = s[SEG_K1];
            end
            PHASE_4:
            begin
                p[0] = s[SEG_F3]; p[1] = s[SEG_D2]; p[2] = s[SEG_C2];
            end
            PHASE_5:
            begin
                p[0] = s[SEG_G3]; p[1] = s[SEG_E2]; p[2] = s[SEG_F2]; p[3] = s[SEG_G2];
            end
            default: ;
        endcase
        return p;
    endfunction

    // Apply one item to the display model; a tick yields the pin drive
    function automatic void display_step(input kind_t k, input logic [7:0] n, input logic e,
                                         output bit has_drive, output drive_exp_t d);
        int   v;
        logic k1;
        logic k2;
        has_drive = 1'b0;
        d = '0;
        case (k)
            KIND_SET:
            begin
                if (n != cached_num)
                begin
                    cached_num = n;
                    v = (n > NUM_CLAMP) ? int'(NUM_CLAMP) : int'(n);
                    k1 = disp_bits[SEG_K1];
                    k2 = disp_bits[SEG_K2];
                    disp_bits = '0;
                    disp_bits[SEG_K1] = k1;
                    disp_bits[SEG_K2] = k2;
                    if (v >= int'(NUM_HUNDRED))
                    begin
                        disp_bits[SEG_B1] = 1'b1;
                        disp_bits[SEG_C1] = 1'b1;
                    end
                    disp_bits[SEG_A2 +: 7] = DIGIT_PAT[(v % int'(NUM_HUNDRED)) / 10];
                    disp_bits[SEG_A3 +: 7] = DIGIT_PAT[v % 10];
                end
            end
            KIND_CLEAR:   disp_bits = '0;
            KIND_CHARGE:  disp_bits[SEG_K1] = e;
            KIND_PERCENT: disp_bits[SEG_K2] = e;
            KIND_TICK:
            begin
                has_drive = 1'b1;
                d.ph = next_phase;
                d.lv = pins_t'(1) << (next_phase - 1);
                d.en = d.lv | lit_pins(next_phase, disp_bits);
                next_phase = (next_phase == PHASE_5) ? PHASE_1 : phase_t'(next_phase + 1);
            end
            default: ;
        endcase
    endfunction

    // Drive one item in bursts with random gaps, then record its expected drive
    task automatic send_item(input kind_t k, input logic [7:0] n, input logic e,
                             input logic typed, input drive_exp_t typed_drive);
        bit         has_drive;
        drive_exp_t d;
        int         gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        in_valid <= 1'b1;
        kind     <= k;
        number   <= n;
        enable   <= e;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        display_step(k, n, e, has_drive, d);
        if (has_drive)
            drive_q.push_back(typed ? typed_drive : d);
    endtask

    // Hold the input off until every pending drive has come out
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (drive_q.size() != 0) @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        kind_t      k;
        logic [7:0] n;
        int         r;
        int         sent;

        disp_bits  = '0;
        cached_num = LAST_RESET;
        next_phase = PHASE_1;

        // Directed table: blank-display ticks are typed in, the rest is modeled
        directed_rows = '{
            '{KIND_TICK,       8'd0,   1'b0, 1'b1, '{5'b00001, 5'b00001, PHASE_1}},
            '{KIND_TICK,       8'd255, 1'b1, 1'b1, '{5'b00010, 5'b00010, PHASE_2}},
            '{KIND_SET,        8'd255, 1'b0, 1'b0, '0},  // repeat of reset cache
            '{KIND_TICK,       8'd0,   1'b0, 1'b1, '{5'b00100, 5'b00100, PHASE_3}},
            '{KIND_SET,        8'd0,   1'b1, 1'b0, '0},  // zero tens shown
            '{KIND_TICK,       8'd0,   1'b0, 1'b0, '0},
            '{KIND_TICK,       8'd0,   1'b0, 1'b0, '0},
            '{KIND_SET,        8'd255, 1'b0, 1'b0, '0},  // clamped to 199
            '{KIND_TICK,       8'd0,   1'b0, 1'b0, '0},
            '{KIND_CHARGE,     8'd0,   1'b1, 1'b0, '0},
            '{KIND_PERCENT,    8'd255, 1'b1, 1'b0, '0},
            '{KIND_TICK,       8'd0,   1'b0, 1'b0, '0},
            '{KIND_TICK,       8'd0,   1'b0, 1'b0, '0},
            '{KIND_SET,        8'd200, 1'b0, 1'b0, '0},
            '{KIND_SET,        8'd100, 1'b0, 1'b0, '0},
            '{KIND_TICK,       8'd0,   1'b0, 1'b0, '0},
            '{KIND_CLEAR,      8'd0,   1'b0, 1'b0, '0},
            '{KIND_TICK,       8'd0,   1'b0, 1'b1, '{5'b10000, 5'b10000, PHASE_5}},
            '{KIND_SET,        8'd100, 1'b0, 1'b0, '0},  // cache survives clear
            '{KIND_TICK,       8'd0,   1'b0, 1'b1, '{5'b00001, 5'b00001, PHASE_1}},
            '{KIND_RSVD_FIRST, 8'd0,   1'b1, 1'b0, '0},
            '{KIND_RSVD_LAST,  8'hAA,  1'b0, 1'b0, '0},
            '{KIND_SET,        8'd9,   1'b0, 1'b0, '0},
            '{KIND_CHARGE,     8'd0,   1'b1, 1'b0, '0},
            '{KIND_TICK,       8'd0,   1'b0, 1'b0, '0}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].kind, directed_rows[i].number, directed_rows[i].enable,
                      directed_rows[i].typed, directed_rows[i].drive);
        pause_until_drained();

        // Random items; ignored kinds do not count
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            n = 8'($urandom_range(0, 255));
            if (r < 40)
                k = KIND_TICK;
            else if (r < 65)
            begin
                k = KIND_SET;
                case ($urandom_range(0, 6))
                    0: n = cached_num;
                    1: n = NUM_CLAMP;
                    2: n = 8'(NUM_CLAMP + 8'd1);
                    3: n = 8'(NUM_HUNDRED - 8'($urandom_range(0, 1)));
                    default: ;
                endcase
            end
            else if (r < 70)
                k = KIND_CLEAR;
            else if (r < 80)
                k = KIND_CHARGE;
            else if (r < 90)
                k = KIND_PERCENT;
            else
                k = kind_t'($urandom_range(KIND_RSVD_FIRST, KIND_RSVD_LAST));
            send_item(k, n, 1'($urandom_range(0, 1)), 1'b0, '0);
            if (k <= KIND_TICK)
                sent++;
            if (sent == PAUSE_AT)
                pause_until_drained();
        end

        // Drain and report
        in_valid <= 1'b0;
        while (drive_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("charlieplex_led_digit_scanner_top: match");
        else
            $display("charlieplex_led_digit_scanner_top: mismatch");
        $finish;
    end

    // Result check and output stall pattern
    always @(posedge clk)
    begin
        drive_exp_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (drive_q.size() == 0)
                begin
                    $display("%0t: unexpected transfer expected none got en=%b lv=%b ph=%0d",
                             $time, drive_enable, drive_level, scan_phase);
                    mismatches++;
                end
                else
                begin
                    want = drive_q.pop_front();
                    if (drive_enable !== want.en)
                    begin
                        $display("%0t: drive_enable expected %b got %b",
                                 $time, want.en, drive_enable);
                        mismatches++;
                    end
                    if (drive_level !== want.lv)
                    begin
                        $display("%0t: drive_level expected %b got %b",
                                 $time, want.lv, drive_level);
                        mismatches++;
                    end
                    if (scan_phase !== want.ph)
                    begin
                        $display("%0t: scan_phase expected %0d got %0d",
                                 $time, want.ph, scan_phase);
                        mismatches++;
                    end
                end
            end

            // Stall modes: none, coin flip, three of four, long runs
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(4, 60);
            end
            stall_left--;
            stall_tick++;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= 1'($urandom_range(0, 1));
                2: out_stall <= (stall_tick % 4) != 0;
                default: out_stall <= (stall_tick % 16) < 12;
            endcase
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("charlieplex_led_digit_scanner_top: mismatch");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

// ===== filelist.f =====
sv/chlx_pkg.sv
sv/chlx_pin_map.sv
sv/charlieplex_led_digit_scanner_top.sv
sv/chlx_checker.sv
test/tb_charlieplex_led_digit_scanner_top.sv
